// ===== hdl/e2dv_pkg.sv =====
// ---------------------------------------------------------------------------
// e2dv_pkg
// shared types, constants and the cordic arctangent table
// ---------------------------------------------------------------------------
`default_nettype none
package e2dv_pkg;

    localparam int ANGLE_W  = 16;
    localparam int COMP_W   = 16;
    localparam int Q_W      = 34;
    localparam int ATAN_ENTRIES = 24;

    typedef logic signed [Q_W-1:0] q30_t;

    localparam q30_t GAIN_Q30    = 34'sd652032874;
    localparam q30_t HALF_PI_Q30 = 34'sd1686629713;
    localparam q30_t PI_Q30      = 34'sd3373259426;

    function automatic q30_t atan_q30(input logic [4:0] idx);
        q30_t r;
        case (idx)
            5'd0:  r = 34'sd843314856;
            5'd1:  r = 34'sd497837829;
            5'd2:  r = 34'sd263043836;
            5'd3:  r = 34'sd133525158;
            5'd4:  r = 34'sd67021686;
            5'd5:  r = 34'sd33543515;
            5'd6:  r = 34'sd16775850;
            5'd7:  r = 34'sd8388437;
            5'd8:  r = 34'sd4194282;
            5'd9:  r = 34'sd2097149;
            5'd10: r = 34'sd1048575;
            5'd11: r = 34'sd524287;
            5'd12: r = 34'sd262143;
            5'd13: r = 34'sd131071;
            5'd14: r = 34'sd65535;
            5'd15: r = 34'sd32767;
            5'd16: r = 34'sd16383;
            5'd17: r = 34'sd8191;
            5'd18: r = 34'sd4095;
            5'd19: r = 34'sd2047;
            5'd20: r = 34'sd1023;
            5'd21: r = 34'sd511;
            5'd22: r = 34'sd255;
            5'd23: r = 34'sd127;
            default: r = '0;
        endcase
        return r;
    endfunction

    // product of two q30 values, rounded back to q30
    function automatic q30_t mul_q30(input q30_t a, input q30_t b);
        logic signed [2*Q_W-1:0] p;
        p = a * b + (68'sd1 <<< 29);
        return q30_t'(p >>> 30);
    endfunction

    function automatic logic signed [COMP_W-1:0] to_q14(input logic signed [Q_W:0] v);
        logic signed [Q_W:0] r;
        r = (v + 35'sd32768) >>> 16;
        if (r > 35'sd16384)
            r = 35'sd16384;
        if (r < -35'sd16384)
            r = -35'sd16384;
        return r[COMP_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== hdl/e2dv_cordic.sv =====
// ---------------------------------------------------------------------------
// e2dv_cordic
// pipelined rotation-mode cordic, one stage per iteration, with stall
// ---------------------------------------------------------------------------
`default_nettype none
module e2dv_cordic #(
    parameter int ITER = 14
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          en,
    input  wire signed [e2dv_pkg::ANGLE_W-1:0] angle,
    output logic signed [e2dv_pkg::Q_W-1:0]    sin_out,
    output logic signed [e2dv_pkg::Q_W-1:0]    cos_out
);
    import e2dv_pkg::*;

    localparam int N = (ITER > ATAN_ENTRIES) ? ATAN_ENTRIES : ITER;

    q30_t x_reg [0:N];
    q30_t y_reg [0:N];
    q30_t z_reg [0:N];
    logic flip_reg [0:N];

    q30_t z0;
    q30_t z_in;
    logic flip_in;

    always_comb
    begin
        z0 = q30_t'(angle) <<< 17;
        flip_in = 1'b0;
        z_in = z0;
        if (z0 > HALF_PI_Q30)
        begin
            z_in = z0 - PI_Q30;
            flip_in = 1'b1;
        end
        else if (z0 < -HALF_PI_Q30)
        begin
            z_in = z0 + PI_Q30;
            flip_in = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= GAIN_Q30;
            y_reg[0] <= '0;
            z_reg[0] <= z_in;
            flip_reg[0] <= flip_in;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_iter
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                flip_reg[i+1] <= flip_reg[i];
                if (!z_reg[i][Q_W-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_q30(5'(i));
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_q30(5'(i));
                end
            end
        end
    end

    assign sin_out = flip_reg[N] ? -y_reg[N] : y_reg[N];
    assign cos_out = flip_reg[N] ? -x_reg[N] : x_reg[N];

    logic unused;
    assign unused = rst_n ^ (^z_reg[N]);

endmodule
`default_nettype wire

// ===== hdl/euler_to_direction_vectors_core.sv =====
// ---------------------------------------------------------------------------
// euler_to_direction_vectors_core
// euler angles to right, up and forward direction vectors via cordic
// ---------------------------------------------------------------------------
// channel  dir  fields (tdata, low bit up)
// s_axis   in   pitch_angle, yaw_angle, roll_angle
// m_axis   out  right_x..z, up_x..z, fwd_x..z
// one request per cycle unless the output stalls; CORDIC_ITERATIONS + 5 register stages
// (iterations capped at 24: cordic input register, one cordic stage per iteration,
// stages a, b and c, and the output register)
// the whole pipeline advances together; m_axis_tready low with a valid output freezes it
// reset clears the valid bits only
`default_nettype none
module euler_to_direction_vectors_core #(
    parameter int CORDIC_ITERATIONS = 14
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [47:0]  s_axis_tdata,   // pitch_angle, yaw_angle, roll_angle
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [143:0] m_axis_tdata    // right_x,y,z, up_x,y,z, fwd_x,y,z
);
    import e2dv_pkg::*;

    localparam int NI = (CORDIC_ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES
                                                           : CORDIC_ITERATIONS;
    localparam int LAT = NI + 5;

    logic en;
    logic [LAT-1:0] vld_reg;
    assign en = !vld_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
    end

    q30_t ps, pc, ys, yc, rs, rc;

    e2dv_cordic #(.ITER(CORDIC_ITERATIONS)) u_pitch (.clk, .rst_n, .en,
        .angle(s_axis_tdata[15:0]), .sin_out(ps), .cos_out(pc));
    e2dv_cordic #(.ITER(CORDIC_ITERATIONS)) u_yaw (.clk, .rst_n, .en,
        .angle(s_axis_tdata[31:16]), .sin_out(ys), .cos_out(yc));
    e2dv_cordic #(.ITER(CORDIC_ITERATIONS)) u_roll (.clk, .rst_n, .en,
        .angle(s_axis_tdata[47:32]), .sin_out(rs), .cos_out(rc));

    // stage a: register trig values, negate pitch cosine
    q30_t sp_reg, cp_reg, ys_reg, yc_reg, rs_reg, rc_reg;
    // stage b: first products
    q30_t spsr_reg, cpsr_reg, b_sp_reg, b_cp_reg, b_ys_reg, b_yc_reg;
    q30_t rcyc_reg, rcys_reg, nrs_reg, sprc_reg, cprc_reg;
    // stage c: second products
    q30_t m0_reg, m1_reg, m2_reg, m3_reg, m4_reg, m5_reg, m6_reg, m7_reg;
    q30_t c_rcyc_reg, c_rcys_reg, c_nrs_reg, c_sprc_reg, c_cprc_reg;
    logic [143:0] out_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sp_reg <= -pc;
            cp_reg <= ps;
            ys_reg <= ys;
            yc_reg <= yc;
            rs_reg <= rs;
            rc_reg <= rc;

            spsr_reg <= mul_q30(sp_reg, rs_reg);
            cpsr_reg <= mul_q30(cp_reg, rs_reg);
            rcyc_reg <= mul_q30(rc_reg, yc_reg);
            rcys_reg <= mul_q30(rc_reg, ys_reg);
            sprc_reg <= mul_q30(sp_reg, rc_reg);
            cprc_reg <= mul_q30(cp_reg, rc_reg);
            nrs_reg  <= -rs_reg;
            b_sp_reg <= sp_reg;
            b_cp_reg <= cp_reg;
            b_ys_reg <= ys_reg;
            b_yc_reg <= yc_reg;

            m0_reg <= mul_q30(spsr_reg, b_yc_reg);
            m1_reg <= mul_q30(b_cp_reg, b_ys_reg);
            m2_reg <= mul_q30(spsr_reg, b_ys_reg);
            m3_reg <= mul_q30(b_cp_reg, b_yc_reg);
            m4_reg <= mul_q30(cpsr_reg, b_yc_reg);
            m5_reg <= mul_q30(b_sp_reg, b_ys_reg);
            m6_reg <= mul_q30(cpsr_reg, b_ys_reg);
            m7_reg <= mul_q30(b_sp_reg, b_yc_reg);
            c_rcyc_reg <= rcyc_reg;
            c_rcys_reg <= rcys_reg;
            c_nrs_reg  <= nrs_reg;
            c_sprc_reg <= sprc_reg;
            c_cprc_reg <= cprc_reg;

            out_reg <= {
                to_q14(35'(c_cprc_reg)),
                to_q14(35'(m6_reg) - 35'(m7_reg)),
                to_q14(35'(m4_reg) + 35'(m5_reg)),
                to_q14(35'(c_sprc_reg)),
                to_q14(35'(m2_reg) + 35'(m3_reg)),
                to_q14(35'(m0_reg) - 35'(m1_reg)),
                to_q14(35'(c_nrs_reg)),
                to_q14(35'(c_rcys_reg)),
                to_q14(35'(c_rcyc_reg))
            };
        end
    end

    assign m_axis_tdata = out_reg;

endmodule
`default_nettype wire
